// ----- hdl/pet_pkg.sv -----
// ----------------------------------------------------------------------------
// pet_pkg
// shared types and constants of the prewitt edge threshold block
// ----------------------------------------------------------------------------
`default_nettype none

package pet_pkg;

   localparam int unsigned CfgWidth = 13;
   localparam int unsigned CfgIndexWidth = 2;

   typedef enum logic [CfgIndexWidth-1:0] {
      REG_FRAME_WIDTH    = 2'd0,
      REG_FRAME_HEIGHT   = 2'd1,
      REG_EDGE_THRESHOLD = 2'd2
   } reg_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      CORE_IDLE  = 2'd0,
      CORE_READ  = 2'd1,
      CORE_EMIT0 = 2'd2,
      CORE_EMIT1 = 2'd3
   } core_state_type;

   typedef enum logic [1:0] {
      MAG_IDLE   = 2'd0,
      MAG_SQUARE = 2'd1,
      MAG_ROOT   = 2'd2,
      MAG_DONE   = 2'd3
   } mag_state_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] magnitude;
      logic       edge_flag;
      logic       frame_end;
   } rsp_payload_type;

   // one window result travelling to the magnitude stage
   typedef struct packed {
      logic signed [10:0] gv;
      logic signed [10:0] gh;
      logic               last;
   } grad_type;

   localparam logic [7:0] MagMax = 8'd255;
   localparam int unsigned MaxHeight = 4096;

endpackage

`default_nettype wire

// ----- hdl/pet_mag.sv -----
// ----------------------------------------------------------------------------
// pet_mag
// gradient to clamped magnitude: squares, one sqrt bit per cycle, threshold
// ----------------------------------------------------------------------------
`default_nettype none

module pet_mag
   import pet_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire grad_type        in_grad,
   input  wire logic [7:0]      threshold,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output rsp_payload_type      out_data
);

   mag_state_type state_ff, state_in;
   logic signed [10:0] gv_ff, gh_ff;
   logic [20:0] sum_ff;
   logic [7:0]  root_ff, root_in;
   logic [7:0]  bit_ff;
   logic        last_ff;
   logic [7:0]  trial;
   logic [15:0] trial_sq;
   logic [20:0] sq_v, sq_h;

   assign trial    = root_ff | bit_ff;
   assign trial_sq = 16'(trial) * 16'(trial);
   assign sq_v     = 21'(21'(gv_ff) * 21'(gv_ff));
   assign sq_h     = 21'(21'(gh_ff) * 21'(gh_ff));

   always_comb begin
      state_in  = state_ff;
      root_in   = root_ff;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         MAG_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) state_in = MAG_SQUARE;
         end
         MAG_SQUARE: begin
            root_in  = '0;
            state_in = MAG_ROOT;
         end
         MAG_ROOT: begin
            if (sum_ff >= 21'd65536) begin
               root_in  = MagMax;
               state_in = MAG_DONE;
            end else begin
               if ({5'b0, trial_sq} <= sum_ff) root_in = trial;
               if (bit_ff[0]) state_in = MAG_DONE;
            end
         end
         MAG_DONE: begin
            out_valid = 1'b1;
            if (out_ready) state_in = MAG_IDLE;
         end
         default: state_in = MAG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MAG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      root_ff <= root_in;
      if (state_ff == MAG_IDLE) begin
         gv_ff   <= in_grad.gv;
         gh_ff   <= in_grad.gh;
         last_ff <= in_grad.last;
      end
      if (state_ff == MAG_SQUARE) begin
         sum_ff <= sq_v + sq_h;
         bit_ff <= 8'h80;
      end else if (state_ff == MAG_ROOT) begin
         bit_ff <= bit_ff >> 1;
      end
   end

   assign out_data.magnitude = root_ff;
   assign out_data.edge_flag = root_ff > threshold;
   assign out_data.frame_end = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == MAG_ROOT && sum_ff >= 21'd65536) |=> root_ff == MagMax)
      else $error("saturated magnitude not clamped");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid && $stable(root_ff))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid))
      else $error("magnitude unit took new work while holding a result");

endmodule

`default_nettype wire

// ----- hdl/pet_core.sv -----
// ----------------------------------------------------------------------------
// pet_core
// line stores, 3x3 window and gradient sums; hands windows to the magnitude unit
// ----------------------------------------------------------------------------
`default_nettype none

module pet_core
   import pet_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 1024
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_payload_type   req_data,
   input  wire logic [10:0]       frame_width,
   input  wire logic [12:0]       frame_height,
   output logic                   grad_valid,
   input  wire logic              grad_ready,
   output grad_type               grad_data
);

   localparam int unsigned AW = $clog2(MAX_WIDTH);

   core_state_type state_ff, state_in;
   logic [7:0] upper_mem [MAX_WIDTH];
   logic [7:0] middle_mem [MAX_WIDTH];
   logic [7:0] upper_rd_ff, middle_rd_ff;

   logic [AW-1:0] col_ff;
   logic [11:0]   row_ff;
   logic          flush_ff;
   logic          flush_req_ff;
   logic [7:0]    gray_ff;
   logic          first_ff, last_col_ff;
   logic [7:0]    win_ff [3][3];   // [column][row]

   logic [AW:0]   w_eff;
   logic [12:0]   h_eff;
   logic          is_flush, accept;
   logic [9:0]    rgb_sum;
   logic [7:0]    gray;
   logic [7:0]    top, mid, bot;
   logic          centre_row0, emits, do_first, do_second;
   logic [7:0]    wl [3], wc [3], wr [3];
   logic [9:0]    s_a, s_b, s_c, s_d;

   // clamp the registers into their legal ranges
   always_comb begin
      if (frame_width == '0) w_eff = (AW+1)'(1);
      else if (32'(frame_width) > MAX_WIDTH) w_eff = (AW+1)'(MAX_WIDTH);
      else w_eff = (AW+1)'(frame_width);
      if (frame_height == '0) h_eff = 13'd1;
      else if (frame_height > 13'(MaxHeight)) h_eff = 13'(MaxHeight);
      else h_eff = frame_height;
   end

   assign is_flush  = req_data.opcode == OP_FLUSH;
   assign req_ready = state_ff == CORE_IDLE;
   assign accept    = req_valid && req_ready && (is_flush == flush_ff);
   assign rgb_sum   = 10'(req_data.red) + 10'(req_data.green) + 10'(req_data.blue);
   // divide by three through a reciprocal: (s*683)>>11 is exact below 1024
   assign gray      = 8'((20'(rgb_sum) * 20'd683) >> 11);

   assign mid = middle_rd_ff;
   assign centre_row0 = flush_ff ? (row_ff == '0) : (row_ff == 12'd1);
   assign bot = flush_ff ? mid : gray_ff;
   assign top = centre_row0 ? mid : upper_rd_ff;
   assign emits = flush_ff || (row_ff != '0);
   assign do_first  = emits && !first_ff;
   assign do_second = emits && last_col_ff;

   // window selection for the emitted result
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (state_ff == CORE_EMIT0) begin
            wl[i] = win_ff[0][i]; wc[i] = win_ff[1][i]; wr[i] = win_ff[2][i];
         end else begin
            wl[i] = win_ff[1][i]; wc[i] = win_ff[2][i]; wr[i] = win_ff[2][i];
         end
      end
      s_a = 10'(wl[2]) + 10'(wc[2]) + 10'(wr[2]);
      s_b = 10'(wl[0]) + 10'(wc[0]) + 10'(wr[0]);
      s_c = 10'(wl[0]) + 10'(wl[1]) + 10'(wl[2]);
      s_d = 10'(wr[0]) + 10'(wr[1]) + 10'(wr[2]);
   end

   assign grad_data.gv   = $signed({1'b0, s_a}) - $signed({1'b0, s_b});
   assign grad_data.gh   = $signed({1'b0, s_c}) - $signed({1'b0, s_d});
   // phase of the request itself: flush_ff has already moved on by now
   assign grad_data.last = (state_ff == CORE_EMIT1) && flush_req_ff;
   assign grad_valid     = state_ff == CORE_EMIT0 || state_ff == CORE_EMIT1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CORE_IDLE: if (accept) state_in = CORE_READ;
         CORE_READ: begin
            if (do_first) state_in = CORE_EMIT0;
            else if (do_second) state_in = CORE_EMIT1;
            else state_in = CORE_IDLE;
         end
         CORE_EMIT0: begin
            if (grad_ready) state_in = last_col_ff ? CORE_EMIT1 : CORE_IDLE;
         end
         CORE_EMIT1: if (grad_ready) state_in = CORE_IDLE;
         default: state_in = CORE_IDLE;
      endcase
   end

   // memories: read on request, write back in the following cycle unless flushing
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_rd_ff  <= upper_mem[col_ff];
         middle_rd_ff <= middle_mem[col_ff];
      end
      if (state_ff == CORE_READ && !flush_ff) begin
         upper_mem[col_ff]  <= mid;
         middle_mem[col_ff] <= bot;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gray_ff      <= gray;
         first_ff     <= col_ff == '0;
         last_col_ff  <= {1'b0, col_ff} >= w_eff - 1'b1;
         flush_req_ff <= flush_ff;
      end
      if (state_ff == CORE_READ) begin
         for (int i = 0; i < 3; i++) begin
            if (first_ff) begin
               win_ff[i][0] <= top; win_ff[i][1] <= mid; win_ff[i][2] <= bot;
            end else if (i < 2) begin
               win_ff[i] <= win_ff[i+1];
            end else begin
               win_ff[i][0] <= top; win_ff[i][1] <= mid; win_ff[i][2] <= bot;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == CORE_READ) begin
            if (last_col_ff) begin
               col_ff <= '0;
               if (flush_ff) begin
                  flush_ff <= 1'b0;
                  row_ff   <= '0;
               end else if (13'(row_ff) >= h_eff - 1'b1) begin
                  flush_ff <= 1'b1;
               end else begin
                  row_ff <= row_ff + 1'b1;
               end
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (grad_valid && !grad_ready) |=> grad_valid && $stable(state_ff))
      else $error("window result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == CORE_READ) |-> !req_ready)
      else $error("request taken during memory access");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == CORE_EMIT1) |-> last_col_ff)
      else $error("right border result outside last column");

endmodule

`default_nettype wire

// ----- hdl/prewitt_edge_threshold.sv -----
// ----------------------------------------------------------------------------
// prewitt_edge_threshold
// streaming 3x3 prewitt edge detector with magnitude threshold
// ----------------------------------------------------------------------------
// requests carry rgb pixels in raster order (opcode pixel) and, after the last
// row, frame_width flush requests (opcode flush). results lag one row: a pixel
// at column x gives the result for x-1 of the row above, the last column gives
// one more; flush requests emit the final row, frame_end set on its last one.
// a request of the wrong kind for the current phase is dropped without result.
// a request is read from the line stores and its window updated in the next
// cycle; its first result passes the square step, eight bit-serial root steps
// and the output step; on saturation the root clamps at its first step. a
// request with no result frees the core after its read step; otherwise the
// core waits for the mag unit to take its window; the root sets the pace.
// a stalled rsp_ready holds the result and, behind it, the next window; no
// result is lost. reset clears counters, phase and window control; line store
// contents stay undefined until written and need no clearing pass. csr writes
// are taken at once; the user writes only while the block is idle, unenforced.
// ----------------------------------------------------------------------------
`default_nettype none

module prewitt_edge_threshold
   import pet_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 1024
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_payload_type          req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_payload_type               rsp_data,
   input  wire logic                     csr_write,
   input  wire logic [CfgIndexWidth-1:0] csr_index,
   input  wire logic [CfgWidth-1:0]      csr_data
);

   logic [10:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic [7:0]  threshold_ff;
   logic        grad_valid, grad_ready;
   grad_type    grad_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 13'd480;
         threshold_ff    <= 8'd128;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH:    frame_width_ff  <= csr_data[10:0];
            REG_FRAME_HEIGHT:   frame_height_ff <= csr_data[12:0];
            REG_EDGE_THRESHOLD: threshold_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   pet_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .grad_valid   (grad_valid),
      .grad_ready   (grad_ready),
      .grad_data    (grad_data)
   );

   pet_mag u_mag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (grad_valid),
      .in_ready  (grad_ready),
      .in_grad   (grad_data),
      .threshold (threshold_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- tb/sv/prewitt_edge_threshold_test.sv -----
// ----------------------------------------------------------------------------
// prewitt_edge_threshold_test
// self-checking bench for the streaming prewitt edge detector
// ----------------------------------------------------------------------------
// frames of rgb pixel requests and their flush requests are streamed into the
// block. Each accepted request updates a bit-true copy of the line stores,
// window and counters, which queues the expected magnitude, edge flag and frame
// end. Each result is checked against the oldest queued expectation. Frame size
// and threshold are reprogrammed between frames, at the extremes and at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prewitt_edge_threshold_test;
   import pet_pkg::*;

   localparam int unsigned LineDepth = 1024;
   localparam int unsigned CycleLimit = 6000000;
   localparam int unsigned SettleCycles = 40;

   class edge_scoreboard;
      byte unsigned upper_row[LineDepth];
      byte unsigned middle_row[LineDepth];
      byte unsigned win[3][3];   // [column][row]
      int unsigned col;
      int unsigned row;
      bit flushing;
      int unsigned width_reg;
      int unsigned height_reg;
      int unsigned thresh_reg;
      rsp_payload_type expected_q[$];
      int unsigned errors;
      int unsigned checked;

      function new();
         foreach (upper_row[i]) begin
            upper_row[i] = 0;
            middle_row[i] = 0;
         end
         foreach (win[i, j]) win[i][j] = 0;
         col = 0;
         row = 0;
         flushing = 0;
         width_reg = 640;
         height_reg = 480;
         thresh_reg = 128;
         errors = 0;
         checked = 0;
      endfunction

      function void set_reg(reg_index_type idx, int unsigned value);
         case (idx)
            REG_FRAME_WIDTH: width_reg = value & 'h7ff;
            REG_FRAME_HEIGHT: height_reg = value & 'h1fff;
            REG_EDGE_THRESHOLD: thresh_reg = value & 'hff;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function rsp_payload_type prewitt(int unsigned l, int unsigned c, int unsigned r,
                                        bit last);
         int gv;
         int gh;
         int unsigned sq;
         int unsigned root;
         int unsigned trial;
         rsp_payload_type res;
         gv = int'(win[l][2]) + win[c][2] + win[r][2] - win[l][0] - win[c][0] - win[r][0];
         gh = int'(win[l][0]) + win[l][1] + win[l][2] - win[r][0] - win[r][1] - win[r][2];
         sq = gv * gv + gh * gh;
         root = 0;
         if (sq >= 65536) begin
            root = 255;
         end else begin
            for (int b = 7; b >= 0; b--) begin
               trial = root | (1 << b);
               if (trial * trial <= sq) root = trial;
            end
         end
         res.magnitude = root[7:0];
         res.edge_flag = root > thresh_reg;
         res.frame_end = last;
         return res;
      endfunction

      function void note_request(req_payload_type p);
         int unsigned w;
         int unsigned h;
         int unsigned x;
         bit last_col;
         bit centre_top;
         bit emits;
         byte unsigned top;
         byte unsigned mid;
         byte unsigned bot;
         w = (width_reg < 1) ? 1 : (width_reg > LineDepth) ? LineDepth : width_reg;
         h = (height_reg < 1) ? 1 : (height_reg > MaxHeight) ? MaxHeight : height_reg;
         if ((p.opcode == OP_FLUSH) != flushing) return;
         x = (col >= LineDepth) ? LineDepth - 1 : col;
         last_col = x >= w - 1;
         mid = middle_row[x];
         if (flushing) begin
            centre_top = row == 0;
            bot = mid;
            emits = 1;
         end else begin
            centre_top = row == 1;
            bot = (int'(p.red) + p.green + p.blue) / 3;
            emits = row >= 1;
         end
         top = centre_top ? mid : upper_row[x];
         if (!flushing) begin
            upper_row[x] = mid;
            middle_row[x] = bot;
         end
         if (x == 0) begin
            for (int i = 0; i < 3; i++) begin
               win[i][0] = top;
               win[i][1] = mid;
               win[i][2] = bot;
            end
         end else begin
            win[0] = win[1];
            win[1] = win[2];
            win[2][0] = top;
            win[2][1] = mid;
            win[2][2] = bot;
         end
         if (emits) begin
            if (x != 0) expected_q.push_back(prewitt(0, 1, 2, 1'b0));
            if (last_col) expected_q.push_back(prewitt(1, 2, 2, flushing));
         end
         if (last_col) begin
            col = 0;
            if (flushing) begin
               flushing = 0;
               row = 0;
            end else if (row >= h - 1) begin
               flushing = 1;
            end else begin
               row = (row + 1) & 'hfff;
            end
         end else begin
            col = x + 1;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         checked++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result mag=%0d edge=%0b end=%0b", $time,
                     got.magnitude, got.edge_flag, got.frame_end);
            return;
         end
         want = expected_q.pop_front();
         if (got.magnitude !== want.magnitude) begin
            errors++;
            $display("%0t: magnitude expected %0d actual %0d", $time,
                     want.magnitude, got.magnitude);
         end
         if (got.edge_flag !== want.edge_flag) begin
            errors++;
            $display("%0t: edge_flag expected %0b actual %0b", $time,
                     want.edge_flag, got.edge_flag);
         end
         if (got.frame_end !== want.frame_end) begin
            errors++;
            $display("%0t: frame_end expected %0b actual %0b", $time,
                     want.frame_end, got.frame_end);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_payload_type rsp_data;
   logic csr_write = 0;
   logic [CfgIndexWidth-1:0] csr_index = '0;
   logic [CfgWidth-1:0] csr_data = '0;

   edge_scoreboard sb = new();
   int unsigned cycles = 0;
   int unsigned frames = 0;
   int unsigned stall_left = 0;
   bit quiet = 0;

   always #4 clock = ~clock;

   prewitt_edge_threshold u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: check, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
      if (reset || quiet) begin
         rsp_ready <= !reset;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end
   end

   task automatic write_reg(reg_index_type idx, int unsigned value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CfgWidth-1:0];
      sb.set_reg(idx, value);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic send(req_payload_type p);
      int unsigned gap;
      gap = quiet ? 0 : ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!req_ready);
      sb.note_request(p);
   endtask

   // hold the sender until every expected result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // mode 0 random colour, mode 1 black or white, mode 2 smooth grey
   function automatic req_payload_type make_req(opcode_type op, int mode);
      req_payload_type p;
      byte unsigned v;
      p.opcode = op;
      p.red = $urandom;
      p.green = $urandom;
      p.blue = $urandom;
      if (mode == 1) begin
         v = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         p.red = v;
         p.green = v;
         p.blue = v;
      end else if (mode == 2) begin
         v = $urandom_range(100, 140);
         p.red = v;
         p.green = v;
         p.blue = v;
      end
      return p;
   endfunction

   task automatic run_frame(int unsigned w, int unsigned h, int mode, int pause_at);
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 19) == 0) send(make_req(OP_FLUSH, 0));
         if (i == pause_at) drain();
         send(make_req(OP_PIXEL, mode));
      end
      for (int i = 0; i < w; i++) begin
         if ($urandom_range(0, 19) == 0) send(make_req(OP_PIXEL, 0));
         send(make_req(OP_FLUSH, 0));
      end
      frames++;
   endtask

   task automatic set_frame(int unsigned w, int unsigned h, int unsigned thr);
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_EDGE_THRESHOLD, thr);
   endtask

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned sent;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme pixels, then degenerate and out of range sizes
      set_frame(3, 2, 0);
      send('{OP_PIXEL, 8'd0, 8'd0, 8'd0});
      send('{OP_PIXEL, 8'd255, 8'd255, 8'd255});
      send('{OP_FLUSH, 8'd255, 8'd0, 8'd255});
      send('{OP_PIXEL, 8'd255, 8'd255, 8'd254});
      send('{OP_PIXEL, 8'd255, 8'd255, 8'd255});
      send('{OP_PIXEL, 8'd0, 8'd0, 8'd0});
      send('{OP_PIXEL, 8'd0, 8'd1, 8'd1});
      send('{OP_FLUSH, 8'd0, 8'd0, 8'd0});
      send('{OP_PIXEL, 8'd170, 8'd85, 8'd255});
      send('{OP_FLUSH, 8'd0, 8'd0, 8'd0});
      send('{OP_FLUSH, 8'd0, 8'd0, 8'd0});
      drain();
      set_frame(0, 0, 255);
      run_frame(1, 1, 1, -1);
      drain();
      set_frame(2, 3, 255);
      run_frame(2, 3, 1, 3);
      drain();

      // random frames, mostly small
      sent = 0;
      while (sent < 400) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         quiet = $urandom_range(0, 3) == 0;
         set_frame(w, h, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1) * 255
                                                   : $urandom_range(0, 255));
         run_frame(w, h, $urandom_range(0, 2),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, w * h - 1) : -1);
         sent += (w + 1) * h;
         drain();
      end
      quiet = 0;

      $display("%0d frames streamed, %0d results checked, small and degenerate sizes",
               frames, sb.checked);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
